@@ rtl/mf3_pkg.sv @@
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types and constants for the 3x3 gray median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package mf3_pkg;

  localparam int PIX_W       = 8;
  localparam int WIN_SIDE    = 3;
  localparam int WIN_N       = 9;
  localparam int MED_IDX     = 4;

  // gray = (r+g+b)/3 as (sum * 683) >> 11, exact for sums up to 765
  localparam int SUM_W       = 10;
  localparam int RECIP3      = 683;
  localparam int RECIP3_SH   = 11;
  localparam int PROD_W      = 20;

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_VAL_W   = 11;
  localparam int CFG_SEL_BIT = 2;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [WIN_N-1:0] win_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    op_t  operation;
    pix_t red;
    pix_t green;
    pix_t blue;
  } in_item_t;

  typedef struct packed {
    pix_t median_gray;
    logic frame_last;
  } out_item_t;

  // 19 compare-exchange median network; slot A takes the minimum
  localparam int NET_N = 19;
  typedef logic [3:0] widx_t;
  localparam widx_t NET_A [NET_N] = '{
    4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd0,
    4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4, 4'd4, 4'd6, 4'd4
  };
  localparam widx_t NET_B [NET_N] = '{
    4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8, 4'd3,
    4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7, 4'd2, 4'd4, 4'd2
  };

endpackage

`default_nettype wire

@@ rtl/mf3_ram.sv @@
// ----------------------------------------------------------------------------
// mf3_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/mf3_gray.sv @@
// ----------------------------------------------------------------------------
// mf3_gray
// RGB to gray, (r+g+b)/3 truncated, by reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_gray
  import mf3_pkg::*;
(
  input  wire pix_t red,
  input  wire pix_t green,
  input  wire pix_t blue,
  output      pix_t gray
);

  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;

  assign sum  = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
  assign prod = PROD_W'(sum) * PROD_W'(RECIP3);
  assign gray = prod[RECIP3_SH +: PIX_W];

endmodule

`default_nettype wire

@@ rtl/mf3_median.sv @@
// ----------------------------------------------------------------------------
// mf3_median
// Median of nine by a fixed compare-exchange network.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_median
  import mf3_pkg::*;
(
  input  wire win_t win,
  output      pix_t median
);

  win_t p;

  always_comb begin
    pix_t lo;
    pix_t hi;
    p = win;
    for (int i = 0; i < NET_N; i++) begin
      lo = p[NET_A[i]];
      hi = p[NET_B[i]];
      if (lo > hi) begin
        p[NET_A[i]] = hi;
        p[NET_B[i]] = lo;
      end
    end
  end

  assign median = p[MED_IDX];

endmodule

`default_nettype wire

@@ rtl/median_filter_3x3_gray_core.sv @@
// ----------------------------------------------------------------------------
// median_filter_3x3_gray_core
// Streaming 3x3 median filter on gray pixels with zero borders.
// ----------------------------------------------------------------------------
// RGB pixels arrive in raster order and are reduced to gray (r+g+b)/3. Each
// result is the median of the 3x3 gray neighbourhood (outside pixels = 0),
// delivered in raster order one row and one pixel behind the input. After the
// last pixel send image_width+1 flush transactions (operation = 1) to drain
// the frame; the final result carries frame_last, after which the next
// transaction starts a new frame. A flush sent before the frame's pixels are
// all in is taken and dropped; a pixel sent after them counts as a flush.
// Rate: one transaction per clock while the output is not stalled. Each result
// passes from the working register to the output register: the gray
// conversion and the line-store reads sit in front of the working register,
// the window shift and median network between it and the output register.
// in_stall rises only when the working register holds a result-producing
// transaction and the output register is full and stalled. Each line store is
// one RAM written and read once a clock; same-column read-after-write (width
// 1, or column zero across a frame restart) is covered by a bypass. Writing
// either register restarts the frame; write only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module median_filter_3x3_gray_core
  import mf3_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // pixel input
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire in_item_t              in_data,
  // result output
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      out_item_t             out_data,
  // register port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output      logic [CFG_DATA_W-1:0] prdata,
  output      logic                  pready
);

  localparam int COLW    = $clog2(MAX_WIDTH);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int HW      = $clog2(MAX_HEIGHT + 1);
  // input row also counts the flush row and the extra flush item
  localparam int ROWW    = $clog2(MAX_HEIGHT + 2);
  localparam int RST_W   = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
  localparam int RST_H   = (MAX_HEIGHT < 480) ? MAX_HEIGHT : 480;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [WW-1:0]        w_r, w_nxt;
  logic [HW-1:0]        h_r, h_nxt;
  logic                 cfg_wr;
  logic [CFG_VAL_W-1:0] cfg_val;
  reg_idx_t             cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_val = pwdata[CFG_VAL_W-1:0];
  assign cfg_sel = reg_idx_t'(paddr[CFG_SEL_BIT]);

  always_comb begin
    w_nxt = w_r;
    h_nxt = h_r;
    if (cfg_wr) begin
      unique case (cfg_sel)
        REG_WIDTH: begin
          if (cfg_val == '0) begin
            w_nxt = WW'(1);
          end else if (int'(cfg_val) > MAX_WIDTH) begin
            w_nxt = WW'(MAX_WIDTH);
          end else begin
            w_nxt = WW'(cfg_val);
          end
        end
        REG_HEIGHT: begin
          if (cfg_val == '0) begin
            h_nxt = HW'(1);
          end else if (int'(cfg_val) > MAX_HEIGHT) begin
            h_nxt = HW'(MAX_HEIGHT);
          end else begin
            h_nxt = HW'(cfg_val);
          end
        end
        default: begin
          w_nxt = w_r;
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_WIDTH:  prdata = CFG_DATA_W'(w_r);
      REG_HEIGHT: prdata = CFG_DATA_W'(h_r);
      default:    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input side: raster counters, gray conversion, line-store read
  // --------------------------------------------------------------------------
  logic [COLW-1:0] col_r, col_nxt;
  logic [ROWW-1:0] row_r, row_nxt;
  logic            in_accept;
  logic            in_take;      // transaction that enters the working register
  logic            in_in_frame;  // pixels of the frame still expected
  logic            in_last;
  pix_t            in_gray;
  pix_t            gray_conv;

  mf3_gray u_gray (
    .red   (in_data.red),
    .green (in_data.green),
    .blue  (in_data.blue),
    .gray  (gray_conv)
  );

  assign in_accept   = in_valid && !in_stall;
  assign in_in_frame = row_r < ROWW'(h_r);
  // early flush: taken, but no state change
  assign in_take     = in_accept && !(in_in_frame && (in_data.operation == OP_FLUSH));
  assign in_gray     = in_in_frame ? gray_conv : '0;
  assign in_last     = (row_r == ROWW'(h_r) + ROWW'(1)) && (col_r == '0);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_take) begin
      if (in_last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (WW'(col_r) + WW'(1) >= w_r) begin
        col_nxt = '0;
        row_nxt = row_r + ROWW'(1);
      end else begin
        col_nxt = col_r + COLW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Working register
  // --------------------------------------------------------------------------
  logic            s1_valid_r, s1_valid_nxt;
  pix_t            s1_gray_r;
  logic [COLW-1:0] s1_col_r;
  logic            s1_ge1_r;
  logic            s1_ge2_r;
  logic            s1_last_r;
  logic            s1_emit;
  logic            s1_commit;

  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_item_r;

  assign s1_emit   = s1_ge2_r || (s1_ge1_r && (s1_col_r != '0));
  assign s1_commit = s1_valid_r && (!s1_emit || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && s1_emit && out_valid_r && out_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_commit) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // line stores: read for the incoming column, written by the committing one
  pix_t up_rd, mid_rd;
  pix_t top, mid;
  logic fwd_hit_r;
  pix_t fwd_up_r;
  pix_t fwd_mid_r;
  pix_t up_eff, mid_eff;

  mf3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_upper (
    .clk   (clk),
    .we    (s1_commit),
    .waddr (s1_col_r),
    .wdata (mid),
    .re    (in_take),
    .raddr (col_r),
    .rdata (up_rd)
  );

  mf3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_middle (
    .clk   (clk),
    .we    (s1_commit),
    .waddr (s1_col_r),
    .wdata (s1_gray_r),
    .re    (in_take),
    .raddr (col_r),
    .rdata (mid_rd)
  );

  // RAM reads first, so a same-edge write to the read column is bypassed
  assign up_eff  = fwd_hit_r ? fwd_up_r  : up_rd;
  assign mid_eff = fwd_hit_r ? fwd_mid_r : mid_rd;
  // rows above the frame read as zero; masks keep unwritten entries unused
  assign top     = s1_ge2_r ? up_eff  : '0;
  assign mid     = s1_ge1_r ? mid_eff : '0;

  // --------------------------------------------------------------------------
  // Window and median
  // --------------------------------------------------------------------------
  win_t cells_r, cells_nxt;
  win_t win;
  pix_t med;
  logic w_ge2;

  assign w_ge2 = w_r >= WW'(2);

  always_comb begin
    cells_nxt = cells_r;
    if (s1_commit) begin
      for (int i = 0; i < 2 * WIN_SIDE; i++) begin
        cells_nxt[i] = cells_r[i + WIN_SIDE];
      end
      cells_nxt[6] = top;
      cells_nxt[7] = mid;
      cells_nxt[8] = s1_gray_r;
    end
  end

  // slot = column * 3 + row; column 0 centres on the last pixel of a row
  always_comb begin
    win = '0;
    for (int i = 0; i < WIN_SIDE; i++) begin
      win[WIN_SIDE + i] = cells_r[2 * WIN_SIDE + i];
    end
    if (s1_col_r == '0) begin
      for (int i = 0; i < WIN_SIDE; i++) begin
        win[i] = w_ge2 ? cells_r[WIN_SIDE + i] : '0;
      end
    end else begin
      for (int i = 0; i < WIN_SIDE; i++) begin
        win[i] = (s1_col_r == COLW'(1)) ? '0 : cells_r[WIN_SIDE + i];
      end
      win[6] = top;
      win[7] = mid;
      win[8] = s1_gray_r;
    end
  end

  mf3_median u_median (
    .win    (win),
    .median (med)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_commit && s1_emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // --------------------------------------------------------------------------
  // Sequential
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r         <= WW'(RST_W);
      h_r         <= HW'(RST_H);
      col_r       <= '0;
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_hit_r   <= 1'b0;
      cells_r     <= '0;
    end else begin
      w_r         <= w_nxt;
      h_r         <= h_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      cells_r     <= cells_nxt;
      if (in_take) begin
        fwd_hit_r <= s1_commit && (s1_col_r == col_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_gray_r <= in_gray;
      s1_col_r  <= col_r;
      s1_ge1_r  <= row_r >= ROWW'(1);
      s1_ge2_r  <= row_r >= ROWW'(2);
      s1_last_r <= in_last;
      fwd_up_r  <= mid;
      fwd_mid_r <= s1_gray_r;
    end
    if (s1_commit && s1_emit) begin
      out_item_r.median_gray <= med;
      out_item_r.frame_last  <= s1_last_r;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(col_r) < w_r)
    else $error("column counter beyond row width");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_emit && out_valid_r))
    else $error("input stalled without a blocked result");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_last && !cfg_wr) |=> (col_r == '0 && row_r == '0))
    else $error("counters not restarted after last transaction of frame");

  // width one, or the first column of a new frame right behind the old one
  a_bypass_width1: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && fwd_hit_r) |-> ((w_r == WW'(1)) || (s1_col_r == '0 && !s1_ge1_r)))
    else $error("line-store bypass taken outside width one or frame start");

  a_last_is_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_last_r) |-> s1_emit)
    else $error("frame end flagged on a transaction without result");

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming 3x3 gray median filter.
// ----------------------------------------------------------------------------
// RGB pixel transactions are queued by the stimulus process and driven by a
// clocked driver. The scoreboard keeps its own line stores, window and frame
// counters. From each accepted transaction it works out the result, if any,
// and checks every result transaction field by field. Geometry registers are
// written over the APB port only while the filter is drained.
// ----------------------------------------------------------------------------

module tb_top;
  import mf3_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_PERIOD   = 12;
  localparam int          MAX_W        = 1024;
  localparam int          MAX_H        = 1024;
  localparam int          RANDOM_ITEMS = 1400;
  localparam int          SETTLE       = 6;
  localparam int          LONG_HOLD    = 300;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  median_filter_3x3_gray_core #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  in_item_t    pixel_stream [$];   // transactions waiting for the driver
  out_item_t   medians_due  [$];   // predicted results, oldest first
  int unsigned mismatches   = 0;
  int unsigned items_sent   = 0;   // pixels and end-of-frame flushes queued
  bit          in_took      = 1'b0;
  bit          no_gaps      = 1'b0;
  bit          long_hold_armed = 1'b0;
  bit          long_hold_used  = 1'b0;
  int          hold_left    = 0;
  int unsigned cycle_count  = 0;

  // Scoreboard's copy of the filter: geometry, line stores, window, counters
  int unsigned img_w, img_h;
  pix_t        row_above [MAX_W];  // gray two rows above the input row
  pix_t        row_prev  [MAX_W];  // gray one row above the input row
  win_t        cells;              // column-major, three cells per column
  int unsigned in_col, in_row, out_col, out_row;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic void restart_frame();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic void reset_filter_model();
    img_w = 640;
    img_h = 480;
    cells = '0;
    foreach (row_above[i]) begin
      row_above[i] = '0;
      row_prev[i]  = '0;
    end
    restart_frame();
  endfunction

  // A register write keeps only the low 11 bits and clamps into 1..max.
  function automatic void apply_register(input logic [CFG_ADDR_W-1:0] addr,
                                         input logic [CFG_DATA_W-1:0] data);
    int unsigned v;
    v = 32'(data[CFG_VAL_W-1:0]);
    if (v < 1) v = 1;
    case (reg_idx_t'(addr[CFG_SEL_BIT]))
      REG_WIDTH:  img_w = (v > MAX_W) ? MAX_W : v;
      REG_HEIGHT: img_h = (v > MAX_H) ? MAX_H : v;
    endcase
    restart_frame();
  endfunction

  // Insertion sort; middle entry of nine
  function automatic pix_t median_of_nine(input win_t v);
    win_t s;
    pix_t key;
    int   k;
    s = v;
    for (int i = 1; i < WIN_N; i++) begin
      key = s[i];
      k   = i - 1;
      while (k >= 0 && s[k] > key) begin
        s[k + 1] = s[k];
        k--;
      end
      s[k + 1] = key;
    end
    return s[MED_IDX];
  endfunction

  // Advances the model by one accepted transaction; returns 1 with a result.
  function automatic bit median_window_step(input in_item_t it, output out_item_t res);
    int unsigned c, r;
    pix_t        g, top, mid;
    win_t        nb;
    bit          emit;
    c   = in_col;
    r   = in_row;
    res = '0;
    // early flush: frame still missing pixels, dropped with no effect
    if (r < img_h && it.operation == OP_FLUSH) return 1'b0;
    g = '0;
    // late pixels past the frame's end count as flushes: colour ignored
    if (r < img_h)
      g = pix_t'((SUM_W'(it.red) + SUM_W'(it.green) + SUM_W'(it.blue)) / 3);

    nb = '0;
    if (c == 0) begin
      // centre sits on the last column of the earlier row
      for (int i = 0; i < WIN_SIDE; i++) begin
        nb[i]     = (img_w >= 2) ? cells[3 + i] : pix_t'(0);
        nb[3 + i] = cells[6 + i];
      end
    end

    top = '0;
    mid = '0;
    if (c < MAX_W) begin
      if (r >= 2) top = row_above[c];
      if (r >= 1) mid = row_prev[c];
      row_above[c] = mid;
      row_prev[c]  = g;
    end
    for (int i = 0; i < 6; i++) cells[i] = cells[i + 3];
    cells[6] = top;
    cells[7] = mid;
    cells[8] = g;

    if (c >= 1) begin
      for (int i = 0; i < WIN_SIDE; i++) begin
        nb[i]     = (c == 1) ? pix_t'(0) : cells[i];
        nb[3 + i] = cells[3 + i];
        nb[6 + i] = cells[6 + i];
      end
    end

    emit = (r >= 2) || (r == 1 && c >= 1);
    c++;
    if (c >= img_w) begin
      c = 0;
      r++;
    end
    in_col = c;
    in_row = r;
    if (!emit) return 1'b0;

    res.median_gray = median_of_nine(nb);
    res.frame_last  = 1'b0;
    if (out_row + 1 >= img_h && out_col + 1 >= img_w) begin
      res.frame_last = 1'b1;
      restart_frame();
    end else begin
      out_col++;
      if (out_col >= img_w) begin
        out_col = 0;
        out_row++;
      end
    end
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic pix_t rand_channel();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return pix_t'($urandom);
  endfunction

  function automatic in_item_t rand_item(input op_t op);
    in_item_t it;
    it.operation = op;
    it.red       = rand_channel();
    it.green     = rand_channel();
    it.blue      = rand_channel();
    return it;
  endfunction

  function automatic in_item_t pixel(input pix_t r, input pix_t g, input pix_t b);
    in_item_t it;
    it.operation = OP_PIXEL;
    it.red       = r;
    it.green     = g;
    it.blue      = b;
    return it;
  endfunction

  // One frame of random pixels and its w+1 closing flushes. A noisy frame
  // may carry stray early flushes, be cut short, or be followed by extra
  // flushes that the filter should ignore.
  function automatic void load_frame(input int unsigned w, input int unsigned h,
                                     input bit noisy);
    int unsigned cut;
    cut = (noisy && $urandom_range(99) < 8) ? $urandom_range(w * h - 1) : w * h;
    for (int unsigned p = 0; p < cut; p++) begin
      if (noisy && $urandom_range(99) < 5) pixel_stream.push_back(rand_item(OP_FLUSH));
      pixel_stream.push_back(rand_item(OP_PIXEL));
    end
    items_sent += cut;
    if (cut < w * h) return;
    // closing flushes; a pixel here acts as a flush
    for (int unsigned t = 0; t <= w; t++)
      pixel_stream.push_back(rand_item(($urandom_range(99) < 20) ? OP_PIXEL : OP_FLUSH));
    items_sent += w + 1;
    if (noisy && $urandom_range(99) < 10)
      repeat ($urandom_range(1, 2)) pixel_stream.push_back(rand_item(OP_FLUSH));
  endfunction

  // APB write: setup phase, then access phase until pready
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] word);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx) << CFG_SEL_BIT;
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // APB read, checked against the scoreboard's geometry
  task automatic read_reg(input reg_idx_t idx);
    logic [CFG_DATA_W-1:0] expect_word;
    expect_word = (idx == REG_WIDTH) ? CFG_DATA_W'(img_w) : CFG_DATA_W'(img_h);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_ADDR_W'(idx) << CFG_SEL_BIT;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== expect_word) begin
      mismatches++;
      $display("%0t: register %0d read mismatch: expected %0d, got %0d",
               $time, idx, expect_word, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait for every queued transaction to be taken and every predicted result
  // to come out, then let the pipeline settle (dropped flushes leave no trace
  // in the result queue).
  task automatic wait_drained();
    while (pixel_stream.size() > 0 || in_valid || medians_due.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Random geometry with junk in the unused upper bits of the data word
  function automatic logic [CFG_DATA_W-1:0] geometry_word(input int unsigned v);
    return {(CFG_DATA_W - CFG_VAL_W)'($urandom), CFG_VAL_W'(v)};
  endfunction

  // --------------------------------------------------------------------------
  // Driver: new transaction at the falling edge once the last one was taken
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pixel_stream.size() > 0 && (no_gaps || $urandom_range(99) >= 15)) begin
        in_data  <= pixel_stream.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side back-pressure, with one long hold to fill the pipeline
  always @(negedge clk) begin
    if (long_hold_armed && !long_hold_used) begin
      hold_left      = LONG_HOLD;
      long_hold_used = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_gaps && ($urandom_range(99) < 15);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor and scoreboard: sample at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    out_item_t predicted;
    out_item_t want;
    if (!rst_n) begin
      reset_filter_model();
      medians_due.delete();
      in_took <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) apply_register(paddr, pwdata);
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        if (median_window_step(in_data, predicted)) medians_due.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        if (medians_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result transaction: expected none, got median %0d last %0b",
                   $time, out_data.median_gray, out_data.frame_last);
        end else begin
          want = medians_due.pop_front();
          if (out_data.median_gray !== want.median_gray) begin
            mismatches++;
            $display("%0t: median_gray mismatch: expected %0d, got %0d",
                     $time, want.median_gray, out_data.median_gray);
          end
          if (out_data.frame_last !== want.frame_last) begin
            mismatches++;
            $display("%0t: frame_last mismatch: expected %0b, got %0b",
                     $time, want.frame_last, out_data.frame_last);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("median_filter_3x3_gray_core verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned w, h, phase;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Reset geometry is 640x480: a stray flush and a few pixels, no result yet
    pixel_stream.push_back(rand_item(OP_FLUSH));
    repeat (3) pixel_stream.push_back(rand_item(OP_PIXEL));
    wait_drained();
    read_reg(REG_WIDTH);
    read_reg(REG_HEIGHT);

    // 3x3 frame with extreme colours, an early flush mid-frame, a late pixel
    // among the closing flushes and a spare flush after frame end
    write_reg(REG_WIDTH, 32'd3);
    write_reg(REG_HEIGHT, 32'd3);
    pixel_stream.push_back(pixel(8'hFF, 8'hFF, 8'hFF));
    pixel_stream.push_back(pixel(8'hFF, 8'hFF, 8'hFE));
    pixel_stream.push_back(pixel(8'h00, 8'h00, 8'h00));
    pixel_stream.push_back(pixel(8'h01, 8'h01, 8'h00));
    pixel_stream.push_back(pixel(8'h02, 8'h00, 8'h00));
    pixel_stream.push_back(rand_item(OP_FLUSH));
    pixel_stream.push_back(pixel(8'h80, 8'h7F, 8'h55));
    pixel_stream.push_back(pixel(8'hFF, 8'h00, 8'h00));
    pixel_stream.push_back(pixel(8'h00, 8'hFF, 8'h00));
    pixel_stream.push_back(pixel(8'h00, 8'h00, 8'hFF));
    pixel_stream.push_back(rand_item(OP_FLUSH));
    pixel_stream.push_back(rand_item(OP_PIXEL));
    pixel_stream.push_back(rand_item(OP_FLUSH));
    pixel_stream.push_back(rand_item(OP_FLUSH));
    pixel_stream.push_back(rand_item(OP_FLUSH));
    wait_drained();

    // Part of a frame, then a width write that must restart it; the write
    // also carries junk above the 11 register bits
    repeat (4) pixel_stream.push_back(rand_item(OP_PIXEL));
    wait_drained();
    write_reg(REG_WIDTH, 32'hFFFF_F801);
    load_frame(1, 3, 1'b0);
    wait_drained();

    // Zero registers clamp to one: a single-pixel frame
    write_reg(REG_HEIGHT, 32'd0);
    write_reg(REG_WIDTH, 32'd0);
    read_reg(REG_WIDTH);
    read_reg(REG_HEIGHT);
    load_frame(1, 1, 1'b0);
    wait_drained();

    // Oversized registers clamp to the maximum; read back, then a few pixels
    // of the top row, which give no result before the next restart
    write_reg(REG_WIDTH, 32'd2047);
    write_reg(REG_HEIGHT, 32'd1100);
    read_reg(REG_WIDTH);
    read_reg(REG_HEIGHT);
    repeat (5) pixel_stream.push_back(rand_item(OP_PIXEL));
    wait_drained();

    // Random phases: new geometry each time, a few frames per phase, a full
    // drain between phases. Phase 0 holds the result side off for a long
    // stretch so the filter backs up; phase 3 runs with no gaps at all.
    items_sent = 0;
    phase      = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (phase == 0) begin
        w = 32;
        h = 8;
      end else begin
        case ($urandom_range(19))
          0:       w = $urandom_range(33, 128);
          1, 2, 3: w = $urandom_range(9, 32);
          default: w = $urandom_range(1, 8);
        endcase
        h = ($urandom_range(4) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
        // wide rows stay short so one phase cannot swamp the item budget
        if (w > 32) h = $urandom_range(1, 4);
      end
      no_gaps = (phase == 3);
      if ($urandom_range(1)) begin
        write_reg(REG_WIDTH, geometry_word(w));
        write_reg(REG_HEIGHT, geometry_word(h));
      end else begin
        write_reg(REG_HEIGHT, geometry_word(h));
        write_reg(REG_WIDTH, geometry_word(w));
      end
      if (phase == 0) begin
        long_hold_armed = 1'b1;
        load_frame(w, h, 1'b0);
      end else begin
        repeat ((w > 32) ? 1 : $urandom_range(1, 3)) load_frame(w, h, 1'b1);
      end
      wait_drained();
      phase++;
    end
    no_gaps = 1'b0;

    wait_drained();
    if (mismatches == 0) begin
      $display("median_filter_3x3_gray_core verification clean");
    end else begin
      $display("median_filter_3x3_gray_core verification failed");
    end
    $finish;
  end

endmodule
